FILE: rtl/uwa_pkg.sv
`default_nettype none

package uwa_pkg;

    // Word store geometry.
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    // Field widths fixed by the interface.
    localparam int OP_W   = 2;
    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 7;

    // Width used for the limit comparison.
    localparam int LIM_W = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

    // Reset value of the word limit.
    localparam logic [CFG_W-1:0] MAX_WORD_RESET = CFG_W'(64);

    // Worst-case bytes appended by one codepoint.
    localparam int MAX_ENC_BYTES = 4;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_FEED  = 2'd0,
        OP_BACK  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CM_WAIT,
        ST_CM_LOAD,
        ST_CM_SEND,
        ST_BK_WAIT,
        ST_BK_CHECK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch codepoint and its encoded length
        logic clear;     // empty the word buffer
        logic write;     // store the next encoded byte
        logic rd_start;  // point the read pointer at the oldest byte
        logic load;      // move read data into the output register
        logic ptr_inc;   // advance the read pointer
        logic bk_start;  // point at the newest byte
        logic bk_dec;    // step back one byte
        logic bk_set;    // truncate the word at the read pointer
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_boundary;  // incoming codepoint ends a word
        logic over_limit;   // appending could exceed the limit
        logic count_zero;   // buffer is empty
        logic wr_last;      // current byte is the last of the codepoint
        logic rd_last;      // read pointer is at the newest byte
        logic bk_stop;      // backspace walk has reached a lead byte or the start
        logic out_taken;    // output item accepted this cycle
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/utf8_word_assembler.sv
// Word assembler for keyboard events, producing committed words as UTF-8 bytes.
// Input channel (s_valid/s_ready): one event per item, s_operation selects feed
// codepoint, backspace or clear; s_codepoint is used only for a feed. The block
// takes one event at a time and raises s_ready only when the previous event is
// fully done. Result channel (m_valid/m_ready): one byte of a committed word per
// item, oldest first, with m_last_byte set on the final byte.
// A clear, an ignored code or a dropped codepoint is handled in the idle state.
// A feed that appends captures the codepoint, then writes its n-byte encoding
// (1 to 4), one store write per cycle. A backspace steps back one byte at a
// time, each step waiting on the store's registered read. A commit streams each
// byte as read, load into the output register, then hand-off, which waits while
// m_ready is low.
// While the receiver stalls, the byte stays in the output register and no new
// event is accepted. cfg_we writes the word limit; write it only while idle.
// Reset empties the word buffer and sets the limit to 64. The store itself is
// not cleared; only bytes below the count are ever read.
`default_nettype none

module utf8_word_assembler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [uwa_pkg::OP_W-1:0]      s_operation,
    input  wire logic [uwa_pkg::CP_W-1:0]      s_codepoint,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [uwa_pkg::BYTE_W-1:0]         m_word_byte,
    output logic                               m_last_byte,
    input  wire logic                          cfg_we,
    input  wire logic [uwa_pkg::CFG_W-1:0]     cfg_wdata
);

    uwa_pkg::cmd_t    cmd;
    uwa_pkg::status_t status;

    // Sequencer for events and commit streaming.
    uwa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .status      (status),
        .cmd         (cmd)
    );

    // Word store, counters, encoder and output register.
    uwa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_codepoint (s_codepoint),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_word_byte (m_word_byte),
        .m_last_byte (m_last_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

FILE: rtl/uwa_ctrl.sv
`default_nettype none

module uwa_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [uwa_pkg::OP_W-1:0]    s_operation,
    input  wire uwa_pkg::status_t            status,
    output uwa_pkg::cmd_t                    cmd
);

    uwa_pkg::state_t state_reg;
    uwa_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uwa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            uwa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (uwa_pkg::op_t'(s_operation))
                        uwa_pkg::OP_FEED: begin
                            if (status.is_boundary) begin
                                if (!status.count_zero) begin
                                    cmd.rd_start = 1'b1;
                                    state_next   = uwa_pkg::ST_CM_WAIT;
                                end
                            end else if (status.over_limit) begin
                                cmd.clear = 1'b1;
                            end else begin
                                cmd.capture = 1'b1;
                                state_next  = uwa_pkg::ST_WRITE;
                            end
                        end
                        uwa_pkg::OP_BACK: begin
                            if (!status.count_zero) begin
                                cmd.bk_start = 1'b1;
                                state_next   = uwa_pkg::ST_BK_WAIT;
                            end
                        end
                        uwa_pkg::OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            uwa_pkg::ST_WRITE: begin
                cmd.write = 1'b1;
                if (status.wr_last) begin
                    state_next = uwa_pkg::ST_IDLE;
                end
            end
            uwa_pkg::ST_CM_WAIT: begin
                state_next = uwa_pkg::ST_CM_LOAD;
            end
            uwa_pkg::ST_CM_LOAD: begin
                cmd.load   = 1'b1;
                state_next = uwa_pkg::ST_CM_SEND;
            end
            uwa_pkg::ST_CM_SEND: begin
                if (status.out_taken) begin
                    if (status.rd_last) begin
                        cmd.clear  = 1'b1;
                        state_next = uwa_pkg::ST_IDLE;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = uwa_pkg::ST_CM_WAIT;
                    end
                end
            end
            uwa_pkg::ST_BK_WAIT: begin
                state_next = uwa_pkg::ST_BK_CHECK;
            end
            uwa_pkg::ST_BK_CHECK: begin
                if (status.bk_stop) begin
                    cmd.bk_set = 1'b1;
                    state_next = uwa_pkg::ST_IDLE;
                end else begin
                    cmd.bk_dec = 1'b1;
                    state_next = uwa_pkg::ST_BK_WAIT;
                end
            end
            default: begin
                state_next = uwa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/uwa_dp.sv
`default_nettype none

module uwa_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [uwa_pkg::CP_W-1:0]      s_codepoint,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [uwa_pkg::BYTE_W-1:0]         m_word_byte,
    output logic                               m_last_byte,
    input  wire logic                          cfg_we,
    input  wire logic [uwa_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire uwa_pkg::cmd_t                 cmd,
    output uwa_pkg::status_t                   status
);

    // Word store, one write and one registered read per cycle.
    logic [uwa_pkg::BYTE_W-1:0] mem [uwa_pkg::STORE_DEPTH];

    logic [uwa_pkg::COUNT_W-1:0] count_reg;
    logic [uwa_pkg::ADDR_W-1:0]  ptr_reg;
    logic [uwa_pkg::CFG_W-1:0]   max_reg;
    logic [uwa_pkg::CP_W-1:0]    cp_reg;
    logic [1:0]                  len_m1_reg;
    logic [1:0]                  k_reg;
    logic [uwa_pkg::BYTE_W-1:0]  rd_data_reg;
    logic [uwa_pkg::BYTE_W-1:0]  out_data_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg;

    logic [1:0]                  len_m1_next;
    logic [uwa_pkg::BYTE_W-1:0]  enc_byte;
    logic [uwa_pkg::LIM_W-1:0]   limit;
    logic [uwa_pkg::LIM_W:0]     needed;
    logic [uwa_pkg::COUNT_W-1:0] ptr_plus1;

    // True for the codepoints that end a word.
    function automatic logic is_boundary(input logic [uwa_pkg::CP_W-1:0] cp);
        logic res;
        res = 1'b0;
        if (cp[uwa_pkg::CP_W-1:7] == '0) begin
            case (cp[6:0])
                7'h00, 7'h09, 7'h0A, 7'h0D, 7'h20, 7'h21, 7'h22, 7'h27,
                7'h28, 7'h29, 7'h2C, 7'h2E, 7'h2F, 7'h3A, 7'h3B, 7'h3C,
                7'h3E, 7'h3F, 7'h5B, 7'h5C, 7'h5D, 7'h7B, 7'h7C, 7'h7D: begin
                    res = 1'b1;
                end
                default: begin
                    res = 1'b0;
                end
            endcase
        end else begin
            res = (cp == uwa_pkg::CP_W'(24'h0000A0)) ||
                  (cp == uwa_pkg::CP_W'(24'h0000AB)) ||
                  (cp == uwa_pkg::CP_W'(24'h0000BB));
        end
        return res;
    endfunction

    // Encoded length minus one of the incoming codepoint.
    always_comb begin
        if (s_codepoint < uwa_pkg::CP_W'(24'h000080)) begin
            len_m1_next = 2'd0;
        end else if (s_codepoint < uwa_pkg::CP_W'(24'h000800)) begin
            len_m1_next = 2'd1;
        end else if (s_codepoint < uwa_pkg::CP_W'(24'h010000)) begin
            len_m1_next = 2'd2;
        end else begin
            len_m1_next = 2'd3;
        end
    end

    // UTF-8 byte number k_reg of the captured codepoint.
    always_comb begin
        enc_byte = '0;
        case (len_m1_reg)
            2'd0: begin
                enc_byte = cp_reg[7:0];
            end
            2'd1: begin
                case (k_reg)
                    2'd0:    enc_byte = {3'b110, cp_reg[10:6]};
                    default: enc_byte = {2'b10, cp_reg[5:0]};
                endcase
            end
            2'd2: begin
                case (k_reg)
                    2'd0:    enc_byte = {4'b1110, cp_reg[15:12]};
                    2'd1:    enc_byte = {2'b10, cp_reg[11:6]};
                    default: enc_byte = {2'b10, cp_reg[5:0]};
                endcase
            end
            default: begin
                case (k_reg)
                    2'd0:    enc_byte = {5'b11110, cp_reg[20:18]};
                    2'd1:    enc_byte = {2'b10, cp_reg[17:12]};
                    2'd2:    enc_byte = {2'b10, cp_reg[11:6]};
                    default: enc_byte = {2'b10, cp_reg[5:0]};
                endcase
            end
        endcase
    end

    // Effective limit is the smaller of the register and the store depth.
    always_comb begin
        if (uwa_pkg::LIM_W'(max_reg) > uwa_pkg::LIM_W'(uwa_pkg::STORE_DEPTH)) begin
            limit = uwa_pkg::LIM_W'(uwa_pkg::STORE_DEPTH);
        end else begin
            limit = uwa_pkg::LIM_W'(max_reg);
        end
        needed = (uwa_pkg::LIM_W+1)'(count_reg) +
                 (uwa_pkg::LIM_W+1)'(uwa_pkg::MAX_ENC_BYTES);
    end

    assign ptr_plus1 = uwa_pkg::COUNT_W'(ptr_reg) + uwa_pkg::COUNT_W'(1);

    // Status toward the controller.
    always_comb begin
        status.is_boundary = is_boundary(s_codepoint);
        status.over_limit  = needed > {1'b0, limit};
        status.count_zero  = (count_reg == '0);
        status.wr_last     = (k_reg == len_m1_reg);
        status.rd_last     = (ptr_plus1 == count_reg);
        status.bk_stop     = (ptr_reg == '0) || (rd_data_reg[7:6] != 2'b10);
        status.out_taken   = out_valid_reg && m_ready;
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= uwa_pkg::MAX_WORD_RESET;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    // Byte count of the buffered word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.write) begin
            count_reg <= count_reg + uwa_pkg::COUNT_W'(1);
        end else if (cmd.bk_set) begin
            count_reg <= uwa_pkg::COUNT_W'(ptr_reg);
        end
    end

    // Captured codepoint and position within its encoding.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cp_reg     <= s_codepoint;
            len_m1_reg <= len_m1_next;
            k_reg      <= 2'd0;
        end else if (cmd.write) begin
            k_reg <= k_reg + 2'd1;
        end
    end

    // Read pointer, shared by commit streaming and the backspace walk.
    always_ff @(posedge aclk) begin
        if (cmd.rd_start) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + uwa_pkg::ADDR_W'(1);
        end else if (cmd.bk_start) begin
            ptr_reg <= uwa_pkg::ADDR_W'(count_reg - uwa_pkg::COUNT_W'(1));
        end else if (cmd.bk_dec) begin
            ptr_reg <= ptr_reg - uwa_pkg::ADDR_W'(1);
        end
    end

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[count_reg[uwa_pkg::ADDR_W-1:0]] <= enc_byte;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_valid_reg && m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= status.rd_last;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_word_byte = out_data_reg;
    assign m_last_byte = out_last_reg;

    // The buffer never holds more bytes than the store.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= uwa_pkg::COUNT_W'(uwa_pkg::STORE_DEPTH))
        else $error("byte count exceeds store depth");

    // No byte is appended while a committed byte is still pending.
    a_no_write_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> !out_valid_reg)
        else $error("store written while output pending");

    // Delivering the last byte of a word leaves the buffer empty.
    a_commit_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_ready && out_last_reg) |=> (count_reg == '0))
        else $error("buffer not empty after commit");

    // A new output byte is never loaded over one that was not yet taken.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !out_valid_reg)
        else $error("output register overrun");

endmodule

`default_nettype wire

FILE: test/tb_utf8_word_assembler.sv
`timescale 1ns / 100ps

module tb_utf8_word_assembler;

    // The fourth operation code has no meaning; the block must ignore it.
    localparam logic [uwa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // A feed writes at most four bytes and a backspace walk examines at most four,
    // so this covers any tail.
    localparam int SETTLE_CYCLES = 200;

    // One byte of a committed word as it should appear on the result channel.
    typedef struct packed {
        logic [uwa_pkg::BYTE_W-1:0] word_byte;
        logic                       last_byte;
    } word_item_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [uwa_pkg::OP_W-1:0]   s_operation;
    logic [uwa_pkg::CP_W-1:0]   s_codepoint;
    logic                       m_valid;
    logic                       m_ready;
    logic [uwa_pkg::BYTE_W-1:0] m_word_byte;
    logic                       m_last_byte;
    logic                       cfg_we;
    logic [uwa_pkg::CFG_W-1:0]  cfg_wdata;

    // Mirror of the word buffer and the limit register.
    logic [uwa_pkg::BYTE_W-1:0] word_buf [uwa_pkg::STORE_DEPTH];
    int                word_len;
    int                word_limit;

    word_item_t        pending_bytes [$];
    int                error_count;
    int                events_sent;
    bit                stalls_on;

    utf8_word_assembler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_codepoint (s_codepoint),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word_byte (m_word_byte),
        .m_last_byte (m_last_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Whitespace, listed punctuation, NUL, no-break space and the guillemets.
    function automatic bit is_word_break(logic [uwa_pkg::CP_W-1:0] cp);
        case (cp)
            21'h00, 21'h09, 21'h0A, 21'h0D, 21'h20, 21'h21, 21'h22, 21'h27,
            21'h28, 21'h29, 21'h2C, 21'h2E, 21'h2F, 21'h3A, 21'h3B, 21'h3C,
            21'h3E, 21'h3F, 21'h5B, 21'h5C, 21'h5D, 21'h7B, 21'h7C, 21'h7D,
            21'hA0, 21'hAB, 21'hBB: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void append_byte(logic [uwa_pkg::BYTE_W-1:0] b);
        if (word_len < uwa_pkg::STORE_DEPTH) begin
            word_buf[word_len] = b;
            word_len++;
        end
    endfunction

    // Values above U+10FFFF still take the four-byte form from all 21 bits.
    function automatic void append_utf8(logic [uwa_pkg::CP_W-1:0] cp);
        if (cp < 21'h80) begin
            append_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end else begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Updates the mirrored buffer for one event and queues any committed bytes.
    function automatic void apply_key_event(logic [uwa_pkg::OP_W-1:0] op,
                                            logic [uwa_pkg::CP_W-1:0] cp);
        int         pos;
        int         eff_limit;
        word_item_t item;
        case (op)
            uwa_pkg::OP_FEED: begin
                if (is_word_break(cp)) begin
                    for (int i = 0; i < word_len; i++) begin
                        item.word_byte = word_buf[i];
                        item.last_byte = (i == word_len - 1);
                        pending_bytes.push_back(item);
                    end
                    word_len = 0;
                end else begin
                    eff_limit = (word_limit > uwa_pkg::STORE_DEPTH) ?
                                uwa_pkg::STORE_DEPTH : word_limit;
                    if (word_len + uwa_pkg::MAX_ENC_BYTES > eff_limit) begin
                        word_len = 0;
                    end else begin
                        append_utf8(cp);
                    end
                end
            end
            uwa_pkg::OP_BACK: begin
                // Walk back over continuation bytes to the lead byte of the last codepoint.
                if (word_len > 0) begin
                    pos = word_len - 1;
                    while (pos > 0 && word_buf[pos][7:6] == 2'b10) pos--;
                    word_len = pos;
                end
            end
            uwa_pkg::OP_CLEAR: begin
                word_len = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // Mostly text-like codepoints of every encoded length, plus raw 21-bit values.
    function automatic logic [uwa_pkg::CP_W-1:0] random_text_cp();
        case ($urandom_range(9))
            0, 1, 2, 3: return uwa_pkg::CP_W'($urandom_range('h23, 'h7E));
            4:          return uwa_pkg::CP_W'($urandom_range('h80, 'h7FF));
            5:          return uwa_pkg::CP_W'($urandom_range('h800, 'hFFFF));
            6:          return uwa_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
            7:          return uwa_pkg::CP_W'($urandom);
            default:    return uwa_pkg::CP_W'($urandom_range('h7F));
        endcase
    endfunction

    function automatic logic [uwa_pkg::CP_W-1:0] random_break_cp();
        logic [uwa_pkg::CP_W-1:0] cp;
        case ($urandom_range(7))
            0: return 21'hA0;
            1: return 21'hAB;
            2: return 21'hBB;
            default: begin
                do cp = uwa_pkg::CP_W'($urandom_range('h7F)); while (!is_word_break(cp));
                return cp;
            end
        endcase
    endfunction

    // Offers one event, with random gaps in front while stalls are on, and predicts it once accepted.
    task automatic send_event(logic [uwa_pkg::OP_W-1:0] op, logic [uwa_pkg::CP_W-1:0] cp);
        while (stalls_on && $urandom_range(99) < 11) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_codepoint <= cp;
        do @(posedge aclk); while (!s_ready);
        apply_key_event(op, cp);
        if (op != OP_UNUSED) events_sent++;
    endtask

    // Stops sending until every committed byte has arrived and the block has settled.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_word_limit(int limit);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= uwa_pkg::CFG_W'(limit);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        word_limit = limit & 'h7F;
    endtask

    // Words of random content closed by a boundary, with edits and some noise.
    task automatic run_random_words(int n_events);
        int burst_base;
        int n_cps;
        burst_base = events_sent;
        while (events_sent - burst_base < n_events) begin
            if ($urandom_range(9) == 0) begin
                send_event(uwa_pkg::OP_W'($urandom), uwa_pkg::CP_W'($urandom));
            end else begin
                n_cps = $urandom_range(1, 20);
                repeat (n_cps) begin
                    case ($urandom_range(24))
                        0, 1:    send_event(uwa_pkg::OP_BACK, uwa_pkg::CP_W'($urandom));
                        2:       send_event(uwa_pkg::OP_CLEAR, uwa_pkg::CP_W'($urandom));
                        3:       send_event(OP_UNUSED, uwa_pkg::CP_W'($urandom));
                        default: send_event(uwa_pkg::OP_FEED, random_text_cp());
                    endcase
                end
                send_event(uwa_pkg::OP_FEED, random_break_cp());
            end
        end
    endtask

    // Every encoded length and range edge in one word, then a break on an empty buffer.
    task automatic test_utf8_lengths();
        send_event(uwa_pkg::OP_FEED, 21'h61);
        send_event(uwa_pkg::OP_FEED, 21'h7F);
        send_event(uwa_pkg::OP_FEED, 21'h80);
        send_event(uwa_pkg::OP_FEED, 21'h7FF);
        send_event(uwa_pkg::OP_FEED, 21'h800);
        send_event(uwa_pkg::OP_FEED, 21'hD800);
        send_event(uwa_pkg::OP_FEED, 21'hFFFF);
        send_event(uwa_pkg::OP_FEED, 21'h10000);
        send_event(uwa_pkg::OP_FEED, 21'h10FFFF);
        send_event(uwa_pkg::OP_FEED, 21'h1FFFFF);
        send_event(uwa_pkg::OP_FEED, 21'h20);
        send_event(uwa_pkg::OP_FEED, 21'h00);
        wait_idle();
    endtask

    // Backspace over multi-byte and empty buffers, clear, and the ignored code.
    task automatic test_edit_events();
        send_event(uwa_pkg::OP_FEED, 21'h10FFFF);
        send_event(uwa_pkg::OP_FEED, 21'h62);
        send_event(uwa_pkg::OP_BACK, 21'h0);
        send_event(uwa_pkg::OP_BACK, 21'h1FFFFF);
        send_event(uwa_pkg::OP_BACK, 21'h0);
        send_event(uwa_pkg::OP_FEED, 21'h63);
        send_event(OP_UNUSED, 21'h1FFFFF);
        send_event(uwa_pkg::OP_CLEAR, 21'h0);
        send_event(uwa_pkg::OP_FEED, 21'hAB);
        send_event(uwa_pkg::OP_FEED, 21'h64);
        send_event(uwa_pkg::OP_FEED, 21'hA0);
        send_event(uwa_pkg::OP_FEED, 21'h800);
        send_event(uwa_pkg::OP_FEED, 21'h65);
        send_event(uwa_pkg::OP_BACK, 21'h0);
        send_event(uwa_pkg::OP_FEED, 21'hBB);
        wait_idle();
    endtask

    // Limits below four, at the edges, above the store depth, and a random one.
    task automatic test_limit_sweep();
        int limits [8];
        limits = '{0, 3, 4, 5, 127, 11, 0, 64};
        limits[6] = $urandom_range(4, 64);
        foreach (limits[k]) begin
            wait_idle();
            write_word_limit(limits[k]);
            run_random_words(10);
        end
        wait_idle();
    endtask

    // A long stretch without stalls, a full drain, then stalls on both sides.
    task automatic test_random_traffic();
        stalls_on = 1'b0;
        run_random_words(60);
        stalls_on = 1'b1;
        wait_idle();
        run_random_words(80);
        wait_idle();
    endtask

    // The receiver stalls at random while stalls are enabled.
    always @(negedge aclk) begin
        m_ready <= !stalls_on || ($urandom_range(99) >= 11);
    end

    // Each accepted result item is compared with the oldest expected byte.
    always @(posedge aclk) begin : check_results
        word_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected item: word_byte=%h last_byte=%b",
                       m_word_byte, m_last_byte);
                error_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_word_byte !== want.word_byte) begin
                    $error("word_byte: expected %h, got %h", want.word_byte, m_word_byte);
                    error_count++;
                end
                if (m_last_byte !== want.last_byte) begin
                    $error("last_byte: expected %b, got %b", want.last_byte, m_last_byte);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = uwa_pkg::OP_FEED;
        s_codepoint = '0;
        m_ready     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = uwa_pkg::MAX_WORD_RESET;
        word_len    = 0;
        word_limit  = uwa_pkg::MAX_WORD_RESET;
        error_count = 0;
        events_sent = 0;
        stalls_on   = 1'b1;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_utf8_lengths();
        test_edit_events();
        test_limit_sweep();
        test_random_traffic();

        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/uwa_pkg.sv
rtl/uwa_ctrl.sv
rtl/uwa_dp.sv
rtl/utf8_word_assembler.sv
test/tb_utf8_word_assembler.sv
